/* hdl/osfc_pkg.sv */
// Package: shared constants, control word types and microprogram for the controller.
`timescale 1ns / 1ps
package osfc_pkg;

   localparam int FRAC_BITS = 13;
   localparam int DATA_W    = 16;
   localparam int OPER_W    = DATA_W + 1;
   localparam int PROD_W    = DATA_W + OPER_W;
   localparam int ACC_W     = 35;
   localparam int SH_W      = ACC_W - FRAC_BITS;
   localparam int DRIVE_W   = 10;
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int NUM_STEPS = 16;
   localparam int STEP_W    = $clog2(NUM_STEPS);

   localparam logic signed [DATA_W-1:0] PHI11 = 16'sd8143;
   localparam logic signed [DATA_W-1:0] PHI12 = 16'sd0;
   localparam logic signed [DATA_W-1:0] PHI21 = 16'sd2042;
   localparam logic signed [DATA_W-1:0] PHI22 = 16'sd8192;
   localparam logic signed [DATA_W-1:0] UNITY = DATA_W'(1 << FRAC_BITS);

   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 10'sd511;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -10'sd512;

   // Register indexes on the configuration port.
   localparam logic [REG_IDX_W-1:0] REG_REF_GAIN    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_STATE1_GAIN = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_STATE2_GAIN = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_OBS1_GAIN   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OBS2_GAIN   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DIST_GAIN   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_INPUT1_GAIN = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_INPUT2_GAIN = 3'd7;

   localparam logic signed [DATA_W-1:0] REG_RESET [NUM_REGS] = '{
      16'sd14607, 16'sd26950, 16'sd14607, 16'sd16680,
      16'sd10191, 16'sd26293, 16'sd919,   16'sd115
   };

   typedef enum logic [3:0] {
      COEF_KR, COEF_K1, COEF_K2, COEF_L1, COEF_L2, COEF_LV, COEF_G1, COEF_G2,
      COEF_UNITY, COEF_PHI11, COEF_PHI12, COEF_PHI21, COEF_PHI22
   } coef_sel_type;

   typedef enum logic [2:0] {
      OPER_R, OPER_X1, OPER_X2, OPER_V, OPER_UV, OPER_E
   } oper_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
   } acc_op_type;

   typedef enum logic [2:0] {
      LATCH_NONE, LATCH_U, LATCH_N1, LATCH_N2, LATCH_NV
   } latch_type;

   typedef struct packed {
      coef_sel_type coef;
      oper_sel_type oper;
      acc_op_type   acc_op;
      latch_type    latch;
      logic         last;
   } ucode_word_type;

   typedef struct packed {
      logic           load_inputs;
      logic           step_en;
      ucode_word_type word;
   } dp_ctrl_type;

   // Latches read the accumulator as it stands before the same step updates it.
   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      unique case (step)
         4'd0:  w = '{COEF_KR,    OPER_R,  ACC_LOAD, LATCH_NONE, 1'b0};
         4'd1:  w = '{COEF_K1,    OPER_X1, ACC_SUB,  LATCH_NONE, 1'b0};
         4'd2:  w = '{COEF_K2,    OPER_X2, ACC_SUB,  LATCH_NONE, 1'b0};
         4'd3:  w = '{COEF_UNITY, OPER_V,  ACC_SUB,  LATCH_NONE, 1'b0};
         4'd4:  w = '{COEF_UNITY, OPER_V,  ACC_HOLD, LATCH_U,    1'b0};
         4'd5:  w = '{COEF_PHI11, OPER_X1, ACC_LOAD, LATCH_NONE, 1'b0};
         4'd6:  w = '{COEF_PHI12, OPER_X2, ACC_ADD,  LATCH_NONE, 1'b0};
         4'd7:  w = '{COEF_G1,    OPER_UV, ACC_ADD,  LATCH_NONE, 1'b0};
         4'd8:  w = '{COEF_L1,    OPER_E,  ACC_ADD,  LATCH_NONE, 1'b0};
         4'd9:  w = '{COEF_PHI21, OPER_X1, ACC_LOAD, LATCH_N1,   1'b0};
         4'd10: w = '{COEF_PHI22, OPER_X2, ACC_ADD,  LATCH_NONE, 1'b0};
         4'd11: w = '{COEF_G2,    OPER_UV, ACC_ADD,  LATCH_NONE, 1'b0};
         4'd12: w = '{COEF_L2,    OPER_E,  ACC_ADD,  LATCH_NONE, 1'b0};
         4'd13: w = '{COEF_UNITY, OPER_V,  ACC_LOAD, LATCH_N2,   1'b0};
         4'd14: w = '{COEF_LV,    OPER_E,  ACC_ADD,  LATCH_NONE, 1'b0};
         4'd15: w = '{COEF_UNITY, OPER_V,  ACC_HOLD, LATCH_NV,   1'b1};
      endcase
      return w;
   endfunction

endpackage

/* hdl/osfc_if.sv */
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
interface osfc_req_if;
   import osfc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] reference;
   logic signed [DATA_W-1:0] measurement;

   modport source (output valid, output reference, output measurement, input ready);
   modport sink   (input valid, input reference, input measurement, output ready);
endinterface

interface osfc_rsp_if;
   import osfc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

/* hdl/osfc_sequencer.sv */
// Sequencer: step counter, microprogram fetch and the wait on a full output register.
`timescale 1ns / 1ps
module osfc_sequencer
   import osfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        out_busy,
   output logic        busy,
   output dp_ctrl_type ctrl
);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_word_type    word;
   logic              stall;
   logic              step_en;

   assign word    = ucode_rom(step_ff);
   // The final step loops on itself until the output register can take the result.
   assign stall   = word.last && out_busy;
   assign step_en = busy_ff && !stall;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (step_en) begin
         if (word.last) begin
            busy_in = 1'b0;
            step_in = '0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign busy             = busy_ff;
   assign ctrl.load_inputs = start;
   assign ctrl.step_en     = step_en;
   assign ctrl.word        = word;

endmodule

/* hdl/osfc_datapath.sv */
// Datapath: gain registers, estimate registers, shared multiplier and accumulator.
`timescale 1ns / 1ps
module osfc_datapath
   import osfc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  dp_ctrl_type               ctrl,
   input  logic signed [DATA_W-1:0]  reference,
   input  logic signed [DATA_W-1:0]  measurement,
   input  logic                      csr_wen,
   input  logic [REG_IDX_W-1:0]      csr_index,
   input  logic [DATA_W-1:0]         csr_wdata,
   output logic signed [DRIVE_W-1:0] drive
);

   logic signed [DATA_W-1:0]  gain_ff [NUM_REGS];
   logic signed [DATA_W-1:0]  x1_ff, x2_ff, v_ff;
   logic signed [DATA_W-1:0]  r_ff, y_ff, e_ff, n1_ff, n2_ff;
   logic signed [DRIVE_W-1:0] u_ff, u_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [DATA_W-1:0]  coef;
   logic signed [OPER_W-1:0]  oper;
   logic signed [OPER_W-1:0]  uv;
   logic signed [PROD_W-1:0]  product;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [SH_W-1:0]    acc_sh;
   logic signed [DATA_W-1:0]  acc_wrap;

   assign uv = OPER_W'(u_ff) + OPER_W'(v_ff);

   always_comb begin
      unique case (ctrl.word.coef)
         COEF_KR:    coef = gain_ff[REG_REF_GAIN];
         COEF_K1:    coef = gain_ff[REG_STATE1_GAIN];
         COEF_K2:    coef = gain_ff[REG_STATE2_GAIN];
         COEF_L1:    coef = gain_ff[REG_OBS1_GAIN];
         COEF_L2:    coef = gain_ff[REG_OBS2_GAIN];
         COEF_LV:    coef = gain_ff[REG_DIST_GAIN];
         COEF_G1:    coef = gain_ff[REG_INPUT1_GAIN];
         COEF_G2:    coef = gain_ff[REG_INPUT2_GAIN];
         COEF_UNITY: coef = UNITY;
         COEF_PHI11: coef = PHI11;
         COEF_PHI12: coef = PHI12;
         COEF_PHI21: coef = PHI21;
         COEF_PHI22: coef = PHI22;
         default:    coef = '0;
      endcase
   end

   always_comb begin
      unique case (ctrl.word.oper)
         OPER_R:  oper = OPER_W'(r_ff);
         OPER_X1: oper = OPER_W'(x1_ff);
         OPER_X2: oper = OPER_W'(x2_ff);
         OPER_V:  oper = OPER_W'(v_ff);
         OPER_UV: oper = uv;
         OPER_E:  oper = OPER_W'(e_ff);
         default: oper = '0;
      endcase
   end

   assign product  = coef * oper;
   assign prod_ext = ACC_W'(product);

   always_comb begin
      unique case (ctrl.word.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
      endcase
   end

   // Floor shift by the fraction width, then saturate or wrap.
   assign acc_sh   = $signed(acc_ff[ACC_W-1:FRAC_BITS]);
   assign acc_wrap = $signed(acc_ff[FRAC_BITS+DATA_W-1:FRAC_BITS]);

   always_comb begin
      if (acc_sh > SH_W'(DRIVE_MAX)) begin
         u_in = DRIVE_MAX;
      end else if (acc_sh < SH_W'(DRIVE_MIN)) begin
         u_in = DRIVE_MIN;
      end else begin
         u_in = acc_sh[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            gain_ff[i] <= REG_RESET[i];
         end
      end else if (csr_wen) begin
         gain_ff[csr_index] <= $signed(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         v_ff  <= '0;
      end else if (ctrl.step_en && ctrl.word.latch == LATCH_NV) begin
         x1_ff <= n1_ff;
         x2_ff <= n2_ff;
         v_ff  <= acc_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_inputs) begin
         r_ff <= reference;
         y_ff <= measurement;
      end
      if (ctrl.step_en) begin
         acc_ff <= acc_in;
         if (ctrl.word.latch == LATCH_U) begin
            u_ff <= u_in;
            e_ff <= y_ff - x2_ff;
         end
         if (ctrl.word.latch == LATCH_N1) begin
            n1_ff <= acc_wrap;
         end
         if (ctrl.word.latch == LATCH_N2) begin
            n2_ff <= acc_wrap;
         end
      end
   end

   assign drive = u_ff;

endmodule

/* hdl/observer_state_feedback_controller.sv */
// Top level: observer-based state feedback controller with disturbance estimate.
`timescale 1ns / 1ps
// Usage. Each request transaction carries a reference and a measured position;
// each one yields exactly one response transaction with the saturated drive value.
// The gain registers are written through the csr_ port (index, data, enable) and
// must be written only while no transaction is in flight.
//
// Timing. The request side is ready whenever no sample is being processed. After
// a request is accepted, a sixteen-step microprogram runs on one shared multiplier
// and one accumulator, at most one multiply-accumulate per step; the response is valid
// right after the sixteenth step. The next request can be accepted as soon as the
// response becomes valid.
//
// Stalls. The result sits in an output register. A new sample may be accepted and
// processed while an earlier response waits; its last step holds until the output
// register is free, and the request side stays not ready meanwhile.
//
// Reset. Synchronous reset clears the estimates, loads the default gains and
// empties the output register. The request side is not ready while reset is high.
module observer_state_feedback_controller
   import osfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   osfc_req_if.sink             req_port,
   osfc_rsp_if.source           rsp_port,
   input  logic                 csr_wen,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   logic                      busy;
   logic                      start;
   logic                      out_busy;
   dp_ctrl_type               ctrl;
   logic signed [DRIVE_W-1:0] dp_drive;
   logic                      commit;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0] drive_ff;

   // No transaction is taken while reset is high, so nothing can be lost there.
   assign req_port.ready = !busy && !reset;
   assign start          = req_port.valid && !busy && !reset;

   // The output register is free when empty or when it is being read this cycle.
   assign out_busy = rsp_valid_ff && !rsp_port.ready;

   osfc_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_busy (out_busy),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   osfc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .reference   (req_port.reference),
      .measurement (req_port.measurement),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .drive       (dp_drive)
   );

   assign commit = ctrl.step_en && ctrl.word.last;

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         drive_ff <= dp_drive;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.drive = drive_ff;

endmodule
